// File: src/bii_pkg.sv
// bii_pkg: shared constants, codes and types for the box intersect index.
// No dependencies; all other files in src/ but bii_ram use its scoped names.
`default_nettype none

package bii_pkg;

  // table geometry
  localparam int CAPACITY    = 64;
  localparam int MAX_DIMS    = 4;
  localparam int COORD_W     = 32;
  localparam int ID_W        = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ND_W        = $clog2(MAX_DIMS + 1);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // field widths fixed by the interface
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int CFG_W       = 3;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [CFG_W-1:0] DIMS_RESET = 3'd2;

  // register indexes
  localparam logic REG_DIMS = 1'b0;

  // input modes
  localparam logic [MODE_W-1:0] MODE_BUILD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef logic [MAX_DIMS-1:0][COORD_W-1:0] coord_vec_t;

  typedef enum logic [1:0] {
    CMD_RESULT,   // single result word, status carried in the command
    CMD_APPEND,   // write one entry, then report accepted
    CMD_QUERY     // scan the table
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [CNT_W-1:0]    slot;   // append: entry index; query: entry count
    logic [ND_W-1:0]     nd;
    coord_vec_t          lo;
    coord_vec_t          hi;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    coord_vec_t      lo;
    coord_vec_t      hi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FLUSH
  } back_state_t;

endpackage

`default_nettype wire

// File: src/bii_ram.sv
// bii_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module bii_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/bii_queue.sv
// bii_queue: short command queue between the front and back of the index.
// Depends on bii_pkg (cmd_t, q_status_t, queue sizing).
`default_nettype none

module bii_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bii_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output bii_pkg::cmd_t     head,
  output bii_pkg::q_status_t q_stat
);

  bii_pkg::cmd_t                   slots [bii_pkg::QUEUE_DEPTH];
  logic [bii_pkg::QPTR_W-1:0]      wr_ptr;
  logic [bii_pkg::QPTR_W-1:0]      rd_ptr;
  logic [bii_pkg::QCNT_W-1:0]      fill;

  function automatic logic [bii_pkg::QPTR_W-1:0] bump(input logic [bii_pkg::QPTR_W-1:0] p);
    bump = (p == bii_pkg::QPTR_W'(bii_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_stat.full  = (fill == bii_pkg::QCNT_W'(bii_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bii_front.sv
// bii_front: accepts words, checks boxes, tracks table fill and build state,
// and turns each word but mode 3 into a back command. Depends on bii_pkg.
`default_nettype none

module bii_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  bii_pkg::q_status_t            q_stat,
  input  logic [bii_pkg::MODE_W-1:0]    mode,
  input  logic [bii_pkg::ID_W-1:0]      entry_id,
  input  bii_pkg::coord_vec_t           lo,
  input  bii_pkg::coord_vec_t           hi,
  input  logic [bii_pkg::ND_W-1:0]      nd,
  output logic                          push,
  output bii_pkg::cmd_t                 push_cmd
);

  logic [bii_pkg::CNT_W-1:0] count;
  logic [bii_pkg::CNT_W-1:0] count_next;
  logic                      failed;
  logic                      failed_next;
  logic                      accept;
  logic                      inverted;

  assign accept = start && !q_stat.full;

  // low > high in any dimension that is compared
  always_comb begin
    inverted = 1'b0;
    for (int d = 0; d < bii_pkg::MAX_DIMS; d++) begin
      if ((bii_pkg::ND_W'(d) < nd) && ($signed(lo[d]) > $signed(hi[d]))) begin
        inverted = 1'b1;
      end
    end
  end

  always_comb begin
    push            = 1'b0;
    count_next      = count;
    failed_next     = failed;
    push_cmd.kind   = bii_pkg::CMD_RESULT;
    push_cmd.status = bii_pkg::ST_ACCEPTED;
    push_cmd.id     = entry_id;
    push_cmd.slot   = count;
    push_cmd.nd     = nd;
    push_cmd.lo     = lo;
    push_cmd.hi     = hi;
    if (accept) begin
      unique case (mode)
        bii_pkg::MODE_BUILD: begin
          push        = 1'b1;
          count_next  = '0;
          failed_next = 1'b0;
        end
        bii_pkg::MODE_APPEND: begin
          push = 1'b1;
          priority if (failed) begin
            push_cmd.status = bii_pkg::ST_REJECTED;
          end else if (inverted) begin
            push_cmd.status = bii_pkg::ST_REJECTED;
            count_next      = '0;
            failed_next     = 1'b1;
          end else if (count >= bii_pkg::CNT_W'(bii_pkg::CAPACITY)) begin
            push_cmd.status = bii_pkg::ST_FULL;
          end else begin
            push_cmd.kind = bii_pkg::CMD_APPEND;
            count_next    = count + 1'b1;
          end
        end
        bii_pkg::MODE_QUERY: begin
          push = 1'b1;
          if ((count == '0) || inverted) begin
            push_cmd.status = bii_pkg::ST_NOMATCH;
          end else begin
            push_cmd.kind = bii_pkg::CMD_QUERY;
          end
        end
        default: begin
          push = 1'b0;   // unused mode: no result, no state change
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      failed <= 1'b0;
    end else begin
      count  <= count_next;
      failed <= failed_next;
    end
  end

endmodule

`default_nettype wire

// File: src/bii_back.sv
// bii_back: executes commands: writes entries, scans the table for queries
// and drives the registered result port. Depends on bii_pkg and bii_ram.
`default_nettype none

module bii_back (
  input  logic                          clk,
  input  logic                          rst,
  input  bii_pkg::cmd_t                 head,
  input  bii_pkg::q_status_t            q_stat,
  output logic                          pop,
  output logic                          valid,
  output logic [bii_pkg::ID_W-1:0]      match_id,
  output logic [bii_pkg::STATUS_W-1:0]  status,
  output logic                          last
);

  bii_pkg::back_state_t state, state_next;

  // captured query
  logic                         load_q;
  logic [bii_pkg::CNT_W-1:0]    q_cnt;
  logic [bii_pkg::ND_W-1:0]     q_nd;
  bii_pkg::coord_vec_t          q_lo;
  bii_pkg::coord_vec_t          q_hi;

  // read issue and data phase
  logic [bii_pkg::CNT_W-1:0]    issue_idx, issue_idx_next;
  logic                         rd_vld, rd_vld_next;
  logic                         rd_final, rd_final_next;

  // last match found, held back until we know whether it is the final one
  logic                         pend_vld, pend_vld_next;
  logic [bii_pkg::ID_W-1:0]     pend_id, pend_id_next;

  logic                         valid_next;
  logic [bii_pkg::ID_W-1:0]     match_id_next;
  logic [bii_pkg::STATUS_W-1:0] status_next;
  logic                         last_next;

  logic                         ram_we;
  logic [bii_pkg::IDX_W-1:0]    raddr;
  logic [bii_pkg::ENTRY_W-1:0]  wdata;
  logic [bii_pkg::ENTRY_W-1:0]  rdata;
  bii_pkg::entry_t              wr_entry;
  bii_pkg::entry_t              rd_entry;
  logic                         hit;

  assign wr_entry.id = head.id;
  assign wr_entry.lo = head.lo;
  assign wr_entry.hi = head.hi;
  assign wdata       = wr_entry;
  assign rd_entry    = bii_pkg::entry_t'(rdata);

  bii_ram #(
    .WIDTH (bii_pkg::ENTRY_W),
    .DEPTH (bii_pkg::CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.slot[bii_pkg::IDX_W-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // inclusive overlap in every compared dimension
  always_comb begin
    hit = 1'b1;
    for (int d = 0; d < bii_pkg::MAX_DIMS; d++) begin
      if ((bii_pkg::ND_W'(d) < q_nd) &&
          !(($signed(rd_entry.hi[d]) >= $signed(q_lo[d])) &&
            ($signed(rd_entry.lo[d]) <= $signed(q_hi[d])))) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    state_next     = state;
    pop            = 1'b0;
    load_q         = 1'b0;
    ram_we         = 1'b0;
    raddr          = issue_idx[bii_pkg::IDX_W-1:0];
    issue_idx_next = issue_idx;
    rd_vld_next    = 1'b0;
    rd_final_next  = 1'b0;
    pend_vld_next  = pend_vld;
    pend_id_next   = pend_id;
    valid_next     = 1'b0;
    match_id_next  = '0;
    status_next    = bii_pkg::ST_ACCEPTED;
    last_next      = 1'b0;
    unique case (state)
      bii_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          unique case (head.kind)
            bii_pkg::CMD_APPEND: begin
              ram_we      = 1'b1;
              valid_next  = 1'b1;
              status_next = bii_pkg::ST_ACCEPTED;
              last_next   = 1'b1;
            end
            bii_pkg::CMD_QUERY: begin
              load_q         = 1'b1;
              raddr          = '0;
              rd_vld_next    = 1'b1;
              rd_final_next  = (head.slot == bii_pkg::CNT_W'(1));
              issue_idx_next = bii_pkg::CNT_W'(1);
              pend_vld_next  = 1'b0;
              state_next     = bii_pkg::B_SCAN;
            end
            default: begin
              valid_next  = 1'b1;
              status_next = head.status;
              last_next   = 1'b1;
            end
          endcase
        end
      end
      bii_pkg::B_SCAN: begin
        if (issue_idx < q_cnt) begin
          rd_vld_next    = 1'b1;
          rd_final_next  = (issue_idx == bii_pkg::CNT_W'(q_cnt - 1'b1));
          issue_idx_next = issue_idx + 1'b1;
        end
        if (rd_vld && hit) begin
          if (pend_vld) begin
            valid_next    = 1'b1;
            match_id_next = pend_id;
            status_next   = bii_pkg::ST_MATCH;
          end
          pend_vld_next = 1'b1;
          pend_id_next  = rd_entry.id;
        end
        if (rd_vld && rd_final) begin
          state_next = bii_pkg::B_FLUSH;
        end
      end
      bii_pkg::B_FLUSH: begin
        valid_next = 1'b1;
        last_next  = 1'b1;
        if (pend_vld) begin
          match_id_next = pend_id;
          status_next   = bii_pkg::ST_MATCH;
        end else begin
          status_next = bii_pkg::ST_NOMATCH;
        end
        state_next = bii_pkg::B_IDLE;
      end
      default: begin
        state_next = bii_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bii_pkg::B_IDLE;
      rd_vld   <= 1'b0;
      pend_vld <= 1'b0;
      valid    <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= rd_vld_next;
      pend_vld <= pend_vld_next;
      valid    <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    issue_idx <= issue_idx_next;
    rd_final  <= rd_final_next;
    pend_id   <= pend_id_next;
    match_id  <= match_id_next;
    status    <= status_next;
    last      <= last_next;
    if (load_q) begin
      q_cnt <= head.slot;
      q_nd  <= head.nd;
      q_lo  <= head.lo;
      q_hi  <= head.hi;
    end
  end

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("back popped an empty queue");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == bii_pkg::B_SCAN))
    else $error("table read data outside a scan");

  a_flush_after_final: assert property (@(posedge clk) disable iff (rst)
    (state == bii_pkg::B_FLUSH) |-> $past(rd_vld && rd_final))
    else $error("flush without the final table entry");

  a_id_only_on_match: assert property (@(posedge clk) disable iff (rst)
    (valid && (status != bii_pkg::ST_MATCH)) |-> (match_id == '0))
    else $error("nonzero id on a non-match result");
`endif

endmodule

`default_nettype wire

// File: src/box_intersect_index.sv
// box_intersect_index: top level, APB register, front, command queue and back.
// Depends on bii_pkg, bii_front, bii_queue, bii_back (which holds bii_ram).
`default_nettype none

// A table of up to 64 axis-aligned boxes (id plus signed low/high bounds in
// up to four dimensions) answering overlap queries. A word is taken at a
// rising edge with start high and busy low; mode selects build start (clears
// the table), append, or query. The front checks each word and updates the
// fill count at once, then queues a command; busy is high only while the
// two-entry command queue is full. The back runs the commands in order:
// build and append words each put their one result on the registered ports
// once the back pops the command (when the back is free). A query reads the
// table through a single registered RAM read port, one entry per cycle, with
// the back in its scan state and then a flush state that sends the final
// result; a query on an empty table or with an inverted box skips the scan
// and gives a single no-match result. Matches come out in stored order, at
// most one per cycle, each with status 1; last marks the final one. A result
// is valid for exactly one cycle with valid high and cannot be held off.
// dims_in_use (APB address 0, reset 2, values above 4 count as 4) is only to
// be written while no word is in flight; mode 3 is dropped silently.
module box_intersect_index (
  input  logic                               clk,
  input  logic                               rst,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [bii_pkg::MODE_W-1:0]         mode,
  input  logic [bii_pkg::ID_W-1:0]           entry_id,
  input  logic signed [bii_pkg::COORD_W-1:0] low_0,
  input  logic signed [bii_pkg::COORD_W-1:0] low_1,
  input  logic signed [bii_pkg::COORD_W-1:0] low_2,
  input  logic signed [bii_pkg::COORD_W-1:0] low_3,
  input  logic signed [bii_pkg::COORD_W-1:0] high_0,
  input  logic signed [bii_pkg::COORD_W-1:0] high_1,
  input  logic signed [bii_pkg::COORD_W-1:0] high_2,
  input  logic signed [bii_pkg::COORD_W-1:0] high_3,
  // result channel
  output logic                               valid,
  output logic [bii_pkg::ID_W-1:0]           match_id,
  output logic [bii_pkg::STATUS_W-1:0]       status,
  output logic                               last,
  // APB register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bii_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bii_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bii_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  logic [bii_pkg::CFG_W-1:0] dims_in_use;
  logic [bii_pkg::ND_W-1:0]  nd;
  logic                      reg_idx;
  logic                      cfg_wr;

  // all four dimensions arrive on ports; only MAX_DIMS of them are kept
  logic [3:0][bii_pkg::COORD_W-1:0] lo_all;
  logic [3:0][bii_pkg::COORD_W-1:0] hi_all;
  bii_pkg::coord_vec_t              lo_vec;
  bii_pkg::coord_vec_t              hi_vec;

  logic                 push;
  logic                 pop;
  bii_pkg::cmd_t        push_cmd;
  bii_pkg::cmd_t        head;
  bii_pkg::q_status_t   q_stat;

  // APB: zero wait states, word addressed registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == bii_pkg::REG_DIMS) ?
                   bii_pkg::APB_DATA_W'(dims_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= bii_pkg::DIMS_RESET;
    end else if (cfg_wr && (reg_idx == bii_pkg::REG_DIMS)) begin
      dims_in_use <= pwdata[bii_pkg::CFG_W-1:0];
    end
  end

  // saturate the dimension count at MAX_DIMS
  assign nd = (dims_in_use > bii_pkg::CFG_W'(bii_pkg::MAX_DIMS)) ?
              bii_pkg::ND_W'(bii_pkg::MAX_DIMS) : dims_in_use[bii_pkg::ND_W-1:0];

  assign lo_all = {low_3, low_2, low_1, low_0};
  assign hi_all = {high_3, high_2, high_1, high_0};
  assign lo_vec = lo_all[bii_pkg::MAX_DIMS-1:0];
  assign hi_vec = hi_all[bii_pkg::MAX_DIMS-1:0];

  assign busy = q_stat.full;

  bii_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .q_stat   (q_stat),
    .mode     (mode),
    .entry_id (entry_id),
    .lo       (lo_vec),
    .hi       (hi_vec),
    .nd       (nd),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bii_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  bii_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .valid    (valid),
    .match_id (match_id),
    .status   (status),
    .last     (last)
  );

endmodule

`default_nettype wire
